### rtl/pee_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Printable escape encoder package
// Shared types, register codes and the hex digit lookup.
// ----------------------------------------------------------------------------
package pee_pkg;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_ESCAPE_CHAR = 2'd0,
        CFG_EIGHT_BIT   = 2'd1,
        CFG_WIDE        = 2'd2
    } t_cfg_idx;

    localparam int unsigned CfgIdxW   = 2;
    localparam int unsigned CfgDataW  = 8;
    localparam int unsigned CodeW     = 16;
    localparam int unsigned ByteW     = 8;
    localparam int unsigned MaxBytes  = 6;
    localparam int unsigned CountW    = 3;

    localparam logic [ByteW-1:0] EscReset = 8'h5C;

    // One classified input: the bytes of its escaped form and how many there are.
    typedef struct packed {
        logic [MaxBytes-1:0][ByteW-1:0] bytes;
        logic [CountW-1:0]              count;
    } t_entry;

    // Lower-case hex digit for one nibble.
    function automatic logic [ByteW-1:0] hex_digit(input logic [3:0] nib);
        logic [ByteW-1:0] r;
        begin
            if (nib < 4'd10) begin
                r = 8'h30 + {4'h0, nib};
            end else begin
                r = 8'h57 + {4'h0, nib};
            end
            return r;
        end
    endfunction

endpackage
`default_nettype wire

### rtl/pee_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Printable escape encoder front end
// Holds the configuration registers and turns each accepted character code
// into a queue word with its complete escaped byte run.
// ----------------------------------------------------------------------------
module pee_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    input  wire logic [pee_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  wire logic [pee_pkg::CfgDataW-1:0]  i_cfg_data,
    input  wire logic [pee_pkg::CodeW-1:0]     i_char_code,
    output pee_pkg::t_entry                    o_entry
);

    logic [7:0]  r_esc;
    logic        r_eight;
    logic        r_wide;

    logic [15:0] code;
    logic [15:0] esc16;
    logic        ascii_ok;
    logic        high_ok;

    // Configuration writes; the port is always ready.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc   <= pee_pkg::EscReset;
            r_eight <= 1'b0;
            r_wide  <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (pee_pkg::t_cfg_idx'(i_cfg_index))
                pee_pkg::CFG_ESCAPE_CHAR: r_esc   <= i_cfg_data;
                pee_pkg::CFG_EIGHT_BIT:   r_eight <= i_cfg_data[0];
                pee_pkg::CFG_WIDE:        r_wide  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Code as seen in the current mode, and the printable tests.
    assign code     = r_wide ? i_char_code : {8'h00, i_char_code[7:0]};
    assign esc16    = {8'h00, r_esc};
    assign ascii_ok = (code >= 16'h0020) && (code < 16'h007F);
    assign high_ok  = !r_wide && r_eight && (code >= 16'h00A0) && (code != 16'h00FF);

    // Build the escaped byte run.
    always_comb begin
        o_entry = '0;
        priority if (code == esc16) begin
            o_entry.bytes[0] = r_esc;
            o_entry.bytes[1] = r_esc;
            o_entry.count    = 3'd2;
        end else if (ascii_ok || high_ok) begin
            o_entry.bytes[0] = code[7:0];
            o_entry.count    = 3'd1;
        end else if (code == 16'h000A) begin
            o_entry.bytes[0] = r_esc;
            o_entry.bytes[1] = 8'h6E;
            o_entry.count    = 3'd2;
        end else if (code == 16'h000D) begin
            o_entry.bytes[0] = r_esc;
            o_entry.bytes[1] = 8'h72;
            o_entry.count    = 3'd2;
        end else if (code == 16'h0009) begin
            o_entry.bytes[0] = r_esc;
            o_entry.bytes[1] = 8'h74;
            o_entry.count    = 3'd2;
        end else if (code == 16'h0000) begin
            o_entry.bytes[0] = r_esc;
            o_entry.bytes[1] = 8'h30;
            o_entry.count    = 3'd2;
        end else if (r_wide) begin
            o_entry.bytes[0] = r_esc;
            o_entry.bytes[1] = 8'h78;
            o_entry.bytes[2] = pee_pkg::hex_digit(code[15:12]);
            o_entry.bytes[3] = pee_pkg::hex_digit(code[11:8]);
            o_entry.bytes[4] = pee_pkg::hex_digit(code[7:4]);
            o_entry.bytes[5] = pee_pkg::hex_digit(code[3:0]);
            o_entry.count    = 3'd6;
        end else begin
            o_entry.bytes[0] = r_esc;
            o_entry.bytes[1] = 8'h78;
            o_entry.bytes[2] = pee_pkg::hex_digit(code[7:4]);
            o_entry.bytes[3] = pee_pkg::hex_digit(code[3:0]);
            o_entry.count    = 3'd4;
        end
    end

endmodule
`default_nettype wire

### rtl/pee_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Printable escape encoder queue
// Two-entry queue of classified words between the front and back ends.
// ----------------------------------------------------------------------------
module pee_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire pee_pkg::t_entry i_wdata,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_nonempty,
    output pee_pkg::t_entry      o_rdata
);

    pee_pkg::t_entry r_mem [2];
    logic            r_wptr;
    logic            r_rptr;
    logic [1:0]      r_count;
    logic [1:0]      n_count;

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    // Pointers and fill level.
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= n_count;
        end
    end

    assign o_full     = (r_count == 2'd2);
    assign o_nonempty = (r_count != 2'd0);
    assign o_rdata    = r_mem[r_rptr];

endmodule
`default_nettype wire

### rtl/pee_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Printable escape encoder back end
// Walks the byte run of the word at the head of the queue, one byte per
// cycle while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module pee_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_q_nonempty,
    input  wire pee_pkg::t_entry            i_q_data,
    output logic                            o_q_pop,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [pee_pkg::ByteW-1:0]       o_out_byte,
    output logic                            o_run_last
);

    logic [pee_pkg::CountW-1:0] r_idx;
    logic [pee_pkg::ByteW-1:0]  r_byte;
    logic                       r_last;
    logic                       r_valid;

    logic                       load;
    logic                       last;
    logic [pee_pkg::ByteW-1:0]  cur_byte;

    // Byte of the head word at the current position.
    always_comb begin
        unique case (r_idx)
            3'd0:    cur_byte = i_q_data.bytes[0];
            3'd1:    cur_byte = i_q_data.bytes[1];
            3'd2:    cur_byte = i_q_data.bytes[2];
            3'd3:    cur_byte = i_q_data.bytes[3];
            3'd4:    cur_byte = i_q_data.bytes[4];
            3'd5:    cur_byte = i_q_data.bytes[5];
            default: cur_byte = '0;
        endcase
    end

    // A byte moves when there is one and the output register is free.
    assign load    = i_q_nonempty && (!r_valid || !i_stall);
    assign last    = (r_idx == (i_q_data.count - 3'd1));
    assign o_q_pop = load && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx <= last ? '0 : r_idx + 3'd1;
            end
            if (load) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= cur_byte;
            r_last <= last;
        end
    end

    assign o_valid    = r_valid;
    assign o_out_byte = r_byte;
    assign o_run_last = r_last;

endmodule
`default_nettype wire

### rtl/printable_escape_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Printable escape encoder
// Turns character codes into their printable backslash-style escaped text.
//
// Input channel: i_valid / o_stall carry one character code per word.
// Output channel: o_valid / i_stall carry one byte of escaped text per word,
// with o_run_last marking the final byte of each input's run (1 to 6 bytes).
// Configuration: i_cfg_valid / o_cfg_ready write escape_char (index 0),
// eight_bit_mode (1) and wide_mode (2); o_cfg_ready is always high.
// The first byte of a run passes from the queue into the output register
// before it appears. Throughput: one output byte per cycle while i_stall is
// low, set by the back end sequencer, so printable text runs at one code per
// cycle.
// A two-word queue sits between classification and byte sequencing; o_stall
// rises when it is full, which happens when the receiver stalls or long runs
// back up. A stalled output byte holds steady.
// Reset clears the queue and output, and loads escape_char 0x5C with both
// mode bits low.
// ----------------------------------------------------------------------------
module printable_escape_encoder (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [pee_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  wire logic [pee_pkg::CfgDataW-1:0]  i_cfg_data,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [pee_pkg::CodeW-1:0]     i_char_code,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [pee_pkg::ByteW-1:0]          o_out_byte,
    output logic                               o_run_last
);

    pee_pkg::t_entry front_entry;
    pee_pkg::t_entry q_data;
    logic            q_full;
    logic            q_nonempty;
    logic            q_pop;
    logic            push;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = q_full;
    assign push        = i_valid && !q_full;

    // Classifier and configuration.
    pee_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_char_code (i_char_code),
        .o_entry     (front_entry)
    );

    // Queue between the two halves.
    pee_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_wdata    (front_entry),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_nonempty (q_nonempty),
        .o_rdata    (q_data)
    );

    // Byte sequencer and output register.
    pee_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_nonempty (q_nonempty),
        .i_q_data     (q_data),
        .o_q_pop      (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last)
    );

endmodule
`default_nettype wire
